/* hdl/smg_pkg.sv */
// smg_pkg: shared types, constants and fixed-point helpers of the spring-mass grid block
// used by smg_ctrl, smg_dpath and the top level; depends on nothing
`default_nettype none

package smg_pkg;

  // widest node address over the supported grid sizes (up to 8x8)
  localparam int ADDR_MAX_W = 6;

  // scaling constants, Q16
  localparam logic [14:0] K_HALF_Q16   = 15'd29491;
  localparam logic [15:0] FRICTION_Q16 = 16'd52429;

  // reciprocal of the mass 15 for 32-bit dividends, shift 35
  localparam logic [31:0] DIV15_RECIP = 32'd2290649225;

  // substep length and reciprocal for the narrow ms accumulator, shift 15
  localparam logic [3:0]  MS_PER_STEP = 4'd15;
  localparam logic [11:0] STEP_RECIP  = 12'd2185;

  localparam logic signed [31:0] BOUND_MAX = 32'sd8388352;
  localparam logic signed [35:0] SAT_HI    = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO    = -36'sd2147483648;

  localparam logic [41:0] VEL_LIMIT   = 42'd128;
  localparam logic [41:0] FORCE_LIMIT = 42'd5120;

  // configuration register indexes
  localparam logic [1:0] REG_REST_X = 2'd0;
  localparam logic [1:0] REG_REST_Y = 2'd1;
  localparam logic [1:0] REG_GRACE  = 2'd2;

  // datapath operations issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_TICK,
    OP_SUB,
    OP_SP_RD,
    OP_SP_DIFF,
    OP_SP_MUL,
    OP_SP_RND,
    OP_SP_WRA,
    OP_SP_WRB,
    OP_ND_RD,
    OP_ND_ABS,
    OP_ND_FMUL,
    OP_ND_FSUB,
    OP_ND_DMUL,
    OP_ND_VADD,
    OP_ND_WR,
    OP_BD_INIT,
    OP_BD_RD,
    OP_BD_CMP,
    OP_BD_ST,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  vert;
    logic                  capture;
    logic [ADDR_MAX_W-1:0] addr_a;
    logic [ADDR_MAX_W-1:0] addr_b;
  } cmd_t;

  typedef struct packed {
    logic [3:0] steps;
  } stat_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // magnitude of a signed 32-bit value
  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    return v[31] ? 33'(-e) : 33'(e);
  endfunction

  // round a Q16 product to nearest, ties away from zero (on the magnitude)
  function automatic logic [32:0] round16(input logic [47:0] p);
    logic [48:0] s;
    s = {1'b0, p} + 49'd32768;
    return s[48:16];
  endfunction

  // clamp to the bounds range, 24-bit result
  function automatic logic [23:0] clampb(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > BOUND_MAX) begin
      r = BOUND_MAX;
    end else if (v < -BOUND_MAX) begin
      r = -BOUND_MAX;
    end else begin
      r = v;
    end
    return r[23:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/smg_ctrl.sv */
// smg_ctrl: sequencer of the spring-mass grid block, walks springs, nodes and bounds
// depends on smg_pkg; drives smg_dpath through cmd_t and reads stat_t
`default_nettype none

module smg_ctrl #(
  parameter int GRID_COLS = 4,
  parameter int GRID_ROWS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_func,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  input  wire smg_pkg::stat_t stat,
  output smg_pkg::cmd_t      cmd
);
  import smg_pkg::*;

  localparam int NODES = GRID_COLS * GRID_ROWS;
  localparam int NA    = $clog2(NODES);
  localparam int CA    = $clog2(GRID_COLS);
  localparam int RA    = $clog2(GRID_ROWS);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LOAD    = 5'd1;
  localparam logic [4:0] S_TICK    = 5'd2;
  localparam logic [4:0] S_CHK     = 5'd3;
  localparam logic [4:0] S_SUB     = 5'd4;
  localparam logic [4:0] S_SEL     = 5'd5;
  localparam logic [4:0] S_SP_RD   = 5'd6;
  localparam logic [4:0] S_SP_DIFF = 5'd7;
  localparam logic [4:0] S_SP_MUL  = 5'd8;
  localparam logic [4:0] S_SP_RND  = 5'd9;
  localparam logic [4:0] S_SP_WRA  = 5'd10;
  localparam logic [4:0] S_SP_WRB  = 5'd11;
  localparam logic [4:0] S_ND_RD   = 5'd12;
  localparam logic [4:0] S_ND_ABS  = 5'd13;
  localparam logic [4:0] S_ND_FMUL = 5'd14;
  localparam logic [4:0] S_ND_FSUB = 5'd15;
  localparam logic [4:0] S_ND_DMUL = 5'd16;
  localparam logic [4:0] S_ND_VADD = 5'd17;
  localparam logic [4:0] S_ND_WR   = 5'd18;
  localparam logic [4:0] S_BD_INIT = 5'd19;
  localparam logic [4:0] S_BD_RD   = 5'd20;
  localparam logic [4:0] S_BD_CMP  = 5'd21;
  localparam logic [4:0] S_BD_ST   = 5'd22;
  localparam logic [4:0] S_OUT     = 5'd23;

  logic [4:0]    state_r, state_nxt;
  logic [NA-1:0] i_r, i_nxt;
  logic [CA-1:0] c_r, c_nxt;
  logic [RA-1:0] r_r, r_nxt;
  logic          vert_r, vert_nxt;
  logic [3:0]    k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          last_node;
  logic          last_col;
  logic          can_out;
  logic          spring_ph;
  logic [NA-1:0] sp_a;
  op_t           op;

  assign last_node = (i_r == NA'(NODES - 1));
  assign last_col  = (c_r == CA'(GRID_COLS - 1));
  assign can_out   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // first node of the current spring: left or upper neighbour
  assign sp_a = vert_r ? (i_r - NA'(GRID_COLS)) : (i_r - NA'(1));
  assign spring_ph = (state_r == S_SP_RD) || (state_r == S_SP_DIFF) ||
                     (state_r == S_SP_MUL) || (state_r == S_SP_RND) ||
                     (state_r == S_SP_WRA) || (state_r == S_SP_WRB);

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    c_nxt     = c_r;
    r_nxt     = r_r;
    vert_nxt  = vert_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_func ? S_TICK : S_LOAD;
        end
      end
      S_LOAD:    state_nxt = S_IDLE;
      S_TICK:    state_nxt = S_CHK;
      S_CHK: begin
        k_nxt     = 4'd0;
        state_nxt = (stat.steps == 4'd0) ? S_OUT : S_SUB;
      end
      S_SUB: begin
        i_nxt     = '0;
        c_nxt     = '0;
        r_nxt     = '0;
        vert_nxt  = 1'b0;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (!vert_r) begin
          if (c_r != '0) begin
            state_nxt = S_SP_RD;
          end else begin
            vert_nxt = 1'b1;
          end
        end else if (r_r != '0) begin
          state_nxt = S_SP_RD;
        end else begin
          vert_nxt = 1'b0;
          if (last_node) begin
            i_nxt     = '0;
            state_nxt = S_ND_RD;
          end else begin
            i_nxt = i_r + NA'(1);
            c_nxt = last_col ? '0 : c_r + CA'(1);
            r_nxt = last_col ? r_r + RA'(1) : r_r;
          end
        end
      end
      S_SP_RD:   state_nxt = S_SP_DIFF;
      S_SP_DIFF: state_nxt = S_SP_MUL;
      S_SP_MUL:  state_nxt = S_SP_RND;
      S_SP_RND:  state_nxt = S_SP_WRA;
      S_SP_WRA:  state_nxt = S_SP_WRB;
      S_SP_WRB: begin
        state_nxt = S_SEL;
        if (!vert_r) begin
          vert_nxt = 1'b1;
        end else begin
          vert_nxt = 1'b0;
          if (last_node) begin
            i_nxt     = '0;
            state_nxt = S_ND_RD;
          end else begin
            i_nxt = i_r + NA'(1);
            c_nxt = last_col ? '0 : c_r + CA'(1);
            r_nxt = last_col ? r_r + RA'(1) : r_r;
          end
        end
      end
      S_ND_RD:   state_nxt = S_ND_ABS;
      S_ND_ABS:  state_nxt = S_ND_FMUL;
      S_ND_FMUL: state_nxt = S_ND_FSUB;
      S_ND_FSUB: state_nxt = S_ND_DMUL;
      S_ND_DMUL: state_nxt = S_ND_VADD;
      S_ND_VADD: state_nxt = S_ND_WR;
      S_ND_WR: begin
        if (last_node) begin
          i_nxt     = '0;
          k_nxt     = k_r + 4'd1;
          state_nxt = ((k_r + 4'd1) == stat.steps) ? S_BD_INIT : S_SUB;
        end else begin
          i_nxt     = i_r + NA'(1);
          state_nxt = S_ND_RD;
        end
      end
      S_BD_INIT: begin
        i_nxt     = '0;
        state_nxt = S_BD_RD;
      end
      S_BD_RD:   state_nxt = S_BD_CMP;
      S_BD_CMP: begin
        if (last_node) begin
          state_nxt = S_BD_ST;
        end else begin
          i_nxt     = i_r + NA'(1);
          state_nxt = S_BD_RD;
        end
      end
      S_BD_ST:   state_nxt = S_OUT;
      S_OUT: begin
        if (can_out) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = (out_valid_r && !out_ready) || ((state_r == S_OUT) && can_out);
  end

  // operation decode
  always_comb begin
    unique case (state_r)
      S_LOAD:    op = OP_LOAD;
      S_TICK:    op = OP_TICK;
      S_SUB:     op = OP_SUB;
      S_SP_RD:   op = OP_SP_RD;
      S_SP_DIFF: op = OP_SP_DIFF;
      S_SP_MUL:  op = OP_SP_MUL;
      S_SP_RND:  op = OP_SP_RND;
      S_SP_WRA:  op = OP_SP_WRA;
      S_SP_WRB:  op = OP_SP_WRB;
      S_ND_RD:   op = OP_ND_RD;
      S_ND_ABS:  op = OP_ND_ABS;
      S_ND_FMUL: op = OP_ND_FMUL;
      S_ND_FSUB: op = OP_ND_FSUB;
      S_ND_DMUL: op = OP_ND_DMUL;
      S_ND_VADD: op = OP_ND_VADD;
      S_ND_WR:   op = OP_ND_WR;
      S_BD_INIT: op = OP_BD_INIT;
      S_BD_RD:   op = OP_BD_RD;
      S_BD_CMP:  op = OP_BD_CMP;
      S_BD_ST:   op = OP_BD_ST;
      S_OUT:     op = can_out ? OP_OUT : OP_IDLE;
      default:   op = OP_IDLE;
    endcase
  end

  assign cmd.op      = op;
  assign cmd.vert    = vert_r;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.addr_a  = ADDR_MAX_W'(spring_ph ? sp_a : i_r);
  assign cmd.addr_b  = ADDR_MAX_W'(i_r);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      c_r         <= '0;
      r_r         <= '0;
      vert_r      <= 1'b0;
      k_r         <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      c_r         <= c_nxt;
      r_r         <= r_nxt;
      vert_r      <= vert_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/smg_dpath.sv */
// smg_dpath: node memories, spring and Euler arithmetic, bounds and result registers
// depends on smg_pkg; sequenced by smg_ctrl through cmd_t
`default_nettype none

module smg_dpath #(
  parameter int GRID_COLS = 4,
  parameter int GRID_ROWS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire smg_pkg::cmd_t      cmd,
  output smg_pkg::stat_t          stat,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [21:0]        cfg_data,
  input  wire logic               in_func,
  input  wire logic [3:0]         in_node_index,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic               in_pinned,
  input  wire logic [6:0]         in_elapsed_ms,
  output logic [2:0]              out_wobble_flags,
  output logic signed [23:0]      out_top_left_x,
  output logic signed [23:0]      out_top_left_y,
  output logic signed [23:0]      out_bottom_right_x,
  output logic signed [23:0]      out_bottom_right_y
);
  import smg_pkg::*;

  localparam int NODES = GRID_COLS * GRID_ROWS;
  localparam int NA    = $clog2(NODES);

  logic [NA-1:0] ra, rb, ld_addr;
  logic          ld_ok;
  logic          rd_op;

  // configuration
  logic [21:0] rest_x_r, rest_y_r;
  logic [7:0]  grace_reload_r;

  // captured input transaction
  logic              ld_func_r;
  logic [3:0]        ld_idx_r;
  logic signed [23:0] ld_px_r, ld_py_r;
  logic              ld_pin_r;
  logic [6:0]        el_r;

  // tick state
  logic [3:0]  frac_r, steps_r;
  logic [7:0]  grace_r;
  logic        gflag_r;
  logic [41:0] vsum_r, fsum_r;

  // per-node flags
  logic [NODES-1:0] vvalid_r, fvalid_r, pinned_r;
  logic             fv_a_r, fv_b_r, vv_a_r;

  // lane results
  logic [31:0] lane_fabs [2];
  logic [32:0] lane_vabs [2];
  logic [23:0] lane_tl [2];
  logic [23:0] lane_br [2];

  // tick arithmetic
  logic [7:0]  acc;
  logic [19:0] acc_prod;
  logic [3:0]  q_steps;
  logic [7:0]  rem;

  logic [2:0]  out_flags_r;
  logic [23:0] out_tlx_r, out_tly_r, out_brx_r, out_bry_r;

  assign ra      = cmd.addr_a[NA-1:0];
  assign rb      = cmd.addr_b[NA-1:0];
  assign ld_addr = NA'(ld_idx_r);
  assign ld_ok   = (7'(ld_idx_r) < 7'(NODES));
  assign rd_op   = (cmd.op == OP_SP_RD) || (cmd.op == OP_ND_RD) || (cmd.op == OP_BD_RD);
  assign stat.steps = steps_r;

  assign acc      = 8'(frac_r) + 8'(el_r);
  assign acc_prod = 20'(acc) * 20'(STEP_RECIP);
  assign q_steps  = acc_prod[18:15];
  assign rem      = acc - 8'(q_steps) * 8'(MS_PER_STEP);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_x_r       <= 22'd0;
      rest_y_r       <= 22'd0;
      grace_reload_r <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REST_X: rest_x_r       <= cfg_data;
        REG_REST_Y: rest_y_r       <= cfg_data;
        REG_GRACE:  grace_reload_r <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ld_func_r <= in_func;
      ld_idx_r  <= in_node_index;
      ld_px_r   <= in_pos_x;
      ld_py_r   <= in_pos_y;
      ld_pin_r  <= in_pinned;
      el_r      <= in_elapsed_ms;
    end
  end

  // tick bookkeeping, node flags and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r   <= 4'd0;
      steps_r  <= 4'd0;
      grace_r  <= 8'd0;
      gflag_r  <= 1'b0;
      vsum_r   <= 42'd0;
      fsum_r   <= 42'd0;
      vvalid_r <= '0;
      fvalid_r <= '0;
      pinned_r <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          grace_r <= grace_reload_r;
          if (ld_ok && !ld_func_r) begin
            pinned_r[ld_addr] <= ld_pin_r;
            vvalid_r[ld_addr] <= 1'b0;
            fvalid_r[ld_addr] <= 1'b0;
          end
        end
        OP_TICK: begin
          steps_r <= q_steps;
          frac_r  <= rem[3:0];
          vsum_r  <= 42'd0;
          fsum_r  <= 42'd0;
          gflag_r <= (grace_r != 8'd0);
          if (grace_r != 8'd0) begin
            grace_r <= grace_r - 8'd1;
          end
        end
        OP_SUB:    fvalid_r <= '0;
        OP_SP_WRA: fvalid_r[ra] <= 1'b1;
        OP_SP_WRB: fvalid_r[rb] <= 1'b1;
        OP_ND_WR: begin
          vvalid_r[ra] <= !pinned_r[ra];
          if (!pinned_r[ra]) begin
            vsum_r <= vsum_r + 42'(lane_vabs[0]) + 42'(lane_vabs[1]);
            fsum_r <= fsum_r + 42'(lane_fabs[0]) + 42'(lane_fabs[1]);
          end
        end
        default: ;
      endcase
    end
  end

  // flag capture alongside memory reads
  always_ff @(posedge clk) begin
    if (rd_op) begin
      fv_a_r <= fvalid_r[ra];
      fv_b_r <= fvalid_r[rb];
      vv_a_r <= vvalid_r[ra];
    end
  end

  // x lane and y lane
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [31:0] pos_mem [NODES];
    logic signed [31:0] vel_mem [NODES];
    logic signed [31:0] frc_mem [NODES];

    logic signed [31:0] pa_r, pb_r, va_r, fa_r, fb_r;
    logic [32:0]        dmag_r;
    logic               dneg_r;
    logic [47:0]        sprod_r;
    logic signed [34:0] sf_r;
    logic signed [31:0] v_r, f_r, fnew_r, vnew_r;
    logic [31:0]        vmag_r, fabs_r;
    logic               vneg_r, fneg_r;
    logic [47:0]        fprod_r;
    logic [63:0]        dprod_r;
    logic signed [31:0] tl_r, br_r;
    logic [23:0]        bnd_tl_r, bnd_br_r;

    logic [21:0]        off;
    logic signed [23:0] lpos;
    logic signed [33:0] diff_c;
    logic [32:0]        sm, fm, vm, fm2;
    logic signed [34:0] smx, fmx;
    logic signed [31:0] fa_g, fb_g, v_g, f_g, pnew;
    logic [31:0]        dn;
    logic [28:0]        qd;
    logic signed [35:0] dvx, dv;

    logic               pos_we, frc_we;
    logic [NA-1:0]      pos_wa, frc_wa;
    logic signed [31:0] pos_wd, frc_wd;

    assign off  = (l == 0) ? (cmd.vert ? 22'd0 : rest_x_r) : (cmd.vert ? rest_y_r : 22'd0);
    assign lpos = (l == 0) ? ld_px_r : ld_py_r;

    // spring arithmetic
    assign diff_c = 34'(pb_r) - 34'(pa_r) - $signed({12'b0, off});
    assign sm     = round16(sprod_r);
    assign smx    = $signed({2'b0, sm});
    assign fa_g   = fv_a_r ? fa_r : 32'sd0;
    assign fb_g   = fv_b_r ? fb_r : 32'sd0;

    // node arithmetic
    assign v_g  = vv_a_r ? va_r : 32'sd0;
    assign f_g  = fa_g;
    assign vm   = mag33(v_g);
    assign fm   = round16(fprod_r);
    assign fmx  = vneg_r ? -$signed({2'b0, fm}) : $signed({2'b0, fm});
    assign fm2  = mag33(fnew_r);
    assign dn   = fm2[31:0] + 32'd7;
    assign qd   = dprod_r[63:35];
    assign dvx  = $signed({7'b0, qd});
    assign dv   = fneg_r ? -dvx : dvx;
    assign pnew = sat32(36'(pa_r) + 36'(vnew_r));

    assign lane_fabs[l] = fabs_r;
    assign lane_vabs[l] = mag33(vnew_r);
    assign lane_tl[l]   = bnd_tl_r;
    assign lane_br[l]   = bnd_br_r;

    // write port selection
    always_comb begin
      pos_we = 1'b0;
      pos_wa = ra;
      pos_wd = pnew;
      if (cmd.op == OP_LOAD) begin
        pos_we = ld_ok && !ld_func_r;
        pos_wa = ld_addr;
        pos_wd = 32'(lpos);
      end else if (cmd.op == OP_ND_WR) begin
        pos_we = !pinned_r[ra];
      end
      frc_we = (cmd.op == OP_SP_WRA) || (cmd.op == OP_SP_WRB);
      frc_wa = (cmd.op == OP_SP_WRB) ? rb : ra;
      frc_wd = (cmd.op == OP_SP_WRB) ? sat32(36'(fb_g) - 36'(sf_r))
                                     : sat32(36'(fa_g) + 36'(sf_r));
    end

    // node memories
    always_ff @(posedge clk) begin
      if (pos_we) begin
        pos_mem[pos_wa] <= pos_wd;
      end
      if ((cmd.op == OP_ND_WR) && !pinned_r[ra]) begin
        vel_mem[ra] <= vnew_r;
      end
      if (frc_we) begin
        frc_mem[frc_wa] <= frc_wd;
      end
      if (rd_op) begin
        pa_r <= pos_mem[ra];
        pb_r <= pos_mem[rb];
        va_r <= vel_mem[ra];
        fa_r <= frc_mem[ra];
        fb_r <= frc_mem[rb];
      end
    end

    // arithmetic stages
    always_ff @(posedge clk) begin
      case (cmd.op)
        OP_SP_DIFF: begin
          dneg_r <= diff_c[33];
          dmag_r <= diff_c[33] ? 33'(-diff_c) : 33'(diff_c);
        end
        OP_SP_MUL:  sprod_r <= 48'(dmag_r) * 48'(K_HALF_Q16);
        OP_SP_RND:  sf_r <= dneg_r ? -smx : smx;
        OP_ND_ABS: begin
          v_r    <= v_g;
          f_r    <= f_g;
          vmag_r <= vm[31:0];
          vneg_r <= v_g[31];
        end
        OP_ND_FMUL: fprod_r <= 48'(vmag_r) * 48'(FRICTION_Q16);
        OP_ND_FSUB: fnew_r <= sat32(36'(f_r) - 36'(fmx));
        OP_ND_DMUL: begin
          dprod_r <= 64'(dn) * 64'(DIV15_RECIP);
          fneg_r  <= fnew_r[31];
          fabs_r  <= fm2[31:0];
        end
        OP_ND_VADD: vnew_r <= sat32(36'(v_r) + dv);
        OP_BD_INIT: begin
          tl_r <= BOUND_MAX;
          br_r <= -BOUND_MAX;
        end
        OP_BD_CMP: begin
          if (pa_r < tl_r) begin
            tl_r <= pa_r;
          end else if (pa_r > br_r) begin
            br_r <= pa_r;
          end
        end
        default: ;
      endcase
    end

    // bounds registers
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        bnd_tl_r <= 24'd0;
        bnd_br_r <= 24'd0;
      end else if (cmd.op == OP_BD_ST) begin
        bnd_tl_r <= clampb(tl_r);
        bnd_br_r <= clampb(br_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_flags_r <= (steps_r == 4'd0) ? 3'b001 :
                     {gflag_r, (fsum_r > FORCE_LIMIT), (vsum_r > VEL_LIMIT)};
      out_tlx_r   <= lane_tl[0];
      out_tly_r   <= lane_tl[1];
      out_brx_r   <= lane_br[0];
      out_bry_r   <= lane_br[1];
    end
  end

  assign out_wobble_flags   = out_flags_r;
  assign out_top_left_x     = $signed(out_tlx_r);
  assign out_top_left_y     = $signed(out_tly_r);
  assign out_bottom_right_x = $signed(out_brx_r);
  assign out_bottom_right_y = $signed(out_bry_r);

endmodule

`default_nettype wire

/* hdl/spring_mass_grid_step.sv */
// spring_mass_grid_step: top level of the spring-mass grid block
// depends on smg_pkg, smg_ctrl and smg_dpath
//
// Usage: a grid of GRID_COLS x GRID_ROWS nodes joined by springs.
// Input channel (in_valid/in_ready): in_func 0 loads one node, 1 is a tick.
// A load produces no result; a tick produces one result transaction on the
// output channel (out_valid/out_ready) carrying the wobble flags and bounds.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
// Each substep walks every spring slot (one horizontal and one vertical per
// node, with one select step per missing slot) and then every node; after
// the last substep a bounds pass walks the nodes. A tick with no whole
// substep skips all of these and goes straight to the result. The pace is
// set by the spring and Euler arithmetic, one unit per lane (x and y),
// shared by all springs and nodes, fed by one node-memory read pair per step.
// One item is worked at a time; in_ready is high only between items.
// The result sits in an output register: a stalled receiver holds it, the
// block keeps taking loads, and a following tick waits at its end until the
// register frees. Reset clears velocities, forces, pinned flags, bounds,
// grace and the ms fraction; node positions are undefined until loaded.
`default_nettype none

module spring_mass_grid_step #(
  parameter int GRID_COLS = 4,
  parameter int GRID_ROWS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [3:0]         in_node_index,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic               in_pinned,
  input  wire logic [6:0]         in_elapsed_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_wobble_flags,
  output logic signed [23:0]      out_top_left_x,
  output logic signed [23:0]      out_top_left_y,
  output logic signed [23:0]      out_bottom_right_x,
  output logic signed [23:0]      out_bottom_right_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [21:0]        cfg_data
);
  import smg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  smg_ctrl #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  smg_dpath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_func            (in_func),
    .in_node_index      (in_node_index),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pinned          (in_pinned),
    .in_elapsed_ms      (in_elapsed_ms),
    .out_wobble_flags   (out_wobble_flags),
    .out_top_left_x     (out_top_left_x),
    .out_top_left_y     (out_top_left_y),
    .out_bottom_right_x (out_bottom_right_x),
    .out_bottom_right_y (out_bottom_right_y)
  );

endmodule

`default_nettype wire

/* hdl/smg_checker.sv */
// smg_checker: port-level assertions for spring_mass_grid_step, bound to the top level
// depends only on the top level's ports
`default_nettype none

module smg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_func,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [23:0] out_top_left_x
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload (checked on out_top_left_x)
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_top_left_x))
    else $error("result payload changed while stalled");

  // a tick transaction keeps the input side closed in the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func |=> !in_ready)
    else $error("input accepted right after a tick");

  // a load transaction never raises a new result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func |=> !(out_valid && !$past(out_valid)))
    else $error("load produced a result");

endmodule

bind spring_mass_grid_step smg_checker u_smg_checker (.*);

`default_nettype wire
